### src/psfp_pkg.sv
// shared constants, request and container codes for the pcm sample fifo packer
// no dependencies
package psfp_pkg;

    localparam int FIFO_DEPTH = 8192;
    localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SAMPLE_W   = 32;
    localparam int QS_W       = 14;
    localparam int BYTES_W    = 3;
    localparam int REQ_W      = 2;
    localparam int FMT_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [FMT_W-1:0] {
        FMT_32 = 2'd0,
        FMT_24 = 2'd1,
        FMT_16 = 2'd2
    } t_fmt;

    localparam logic [BYTES_W-1:0] BYTES_32 = 3'd4;
    localparam logic [BYTES_W-1:0] BYTES_24 = 3'd3;
    localparam logic [BYTES_W-1:0] BYTES_16 = 3'd2;

endpackage

### src/pcm_sample_fifo_packer.sv
// pcm sample fifo packer: ring fifo of 32-bit samples with wire container conversion
// depends on psfp_pkg and psfp_ram
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one request: write a sample,
//   pop a sample, or clear. every request gives exactly one result on the output
//   channel (o_out_valid / i_out_stall).
//   config channel (i_cfg_valid / o_cfg_ready) writes the container format;
//   it is always ready and must only be written while the block is idle.
// a result is registered and appears in the cycle after its request is taken.
// throughput: one request per cycle unless the receiver stalls; the sample memory
//   is read at the request edge and its registered read data feeds the output stage directly.
// a write is stored at the request edge, so a pop right behind it sees the data.
// reset clears the indices, the fill count, the format and the output valid flag;
//   the sample memory is not cleared and needs no clearing pass.
// when the receiver stalls, the result holds and o_in_stall rises so that no
//   further request is taken until the result is delivered.
module pcm_sample_fifo_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psfp_pkg::REQ_W-1:0]    i_req_type,
    input  logic signed [psfp_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psfp_pkg::SAMPLE_W-1:0] o_wire_word,
    output logic [psfp_pkg::BYTES_W-1:0]  o_word_bytes,
    output logic                          o_accepted,
    output logic                          o_underrun,
    output logic [psfp_pkg::QS_W-1:0]     o_queued_samples,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psfp_pkg::FMT_W-1:0]    i_cfg_data
);
    import psfp_pkg::*;

    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [FMT_W-1:0]    r_fmt;

    logic                r_o_valid;
    logic                r_o_hit, n_o_hit;
    logic [FMT_W-1:0]    r_o_fmt;
    logic [BYTES_W-1:0]  r_o_bytes, n_o_bytes;
    logic                r_o_acc, n_o_acc;
    logic                r_o_und, n_o_und;
    logic [QS_W-1:0]     r_o_qs;

    logic                take;
    logic                ram_we;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] pop_val;

    assign o_in_stall  = r_o_valid & i_out_stall;
    assign take        = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_count   = r_count;
        n_o_hit   = 1'b0;
        n_o_bytes = '0;
        n_o_acc   = 1'b0;
        n_o_und   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (t_req'(i_req_type))
            REQ_WRITE: begin
                if (r_count != CNT_W'(FIFO_DEPTH)) begin
                    ram_we   = take;
                    n_wr_idx = step_idx(r_wr_idx);
                    n_count  = r_count + 1'b1;
                    n_o_acc  = 1'b1;
                end
            end
            REQ_POP: begin
                case (t_fmt'(r_fmt))
                    FMT_32:  n_o_bytes = BYTES_32;
                    FMT_24:  n_o_bytes = BYTES_24;
                    default: n_o_bytes = BYTES_16;
                endcase
                if (r_count != '0) begin
                    ram_re   = take;
                    n_o_hit  = 1'b1;
                    n_rd_idx = step_idx(r_rd_idx);
                    n_count  = r_count - 1'b1;
                end else begin
                    n_o_und = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_rd_idx = '0;
                n_wr_idx = '0;
                n_count  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_wr_idx  <= '0;
            r_count   <= '0;
            r_fmt     <= FMT_W'(FMT_32);
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fmt <= i_cfg_data;
            end
            if (take) begin
                r_rd_idx  <= n_rd_idx;
                r_wr_idx  <= n_wr_idx;
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload of the output stage, loaded with each request
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_hit   <= n_o_hit;
            r_o_fmt   <= r_fmt;
            r_o_bytes <= n_o_bytes;
            r_o_acc   <= n_o_acc;
            r_o_und   <= n_o_und;
            r_o_qs    <= QS_W'(n_count);
        end
    end

    psfp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FIFO_DEPTH),
        .ADDR_W(IDX_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wr_idx),
        .i_wdata(i_sample),
        .i_re   (ram_re),
        .i_raddr(r_rd_idx),
        .o_rdata(ram_rdata)
    );

    // read data only holds a sample for a pop that hit a stored entry
    assign pop_val = r_o_hit ? ram_rdata : '0;

    always_comb begin
        case (t_fmt'(r_o_fmt))
            FMT_32:  o_wire_word = pop_val;
            FMT_24:  o_wire_word = {8'd0, pop_val[SAMPLE_W-1:8]};
            default: o_wire_word = {16'd0, pop_val[SAMPLE_W-1:16]};
        endcase
    end

    assign o_out_valid      = r_o_valid;
    assign o_word_bytes     = r_o_bytes;
    assign o_accepted       = r_o_acc;
    assign o_underrun       = r_o_und;
    assign o_queued_samples = r_o_qs;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("fill count above fifo depth");

    a_empty_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_idx == r_wr_idx))
        else $error("empty fifo with read and write index apart");

    a_acc_und_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_underrun))
        else $error("result flagged both accepted and underrun");

    a_und_is_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_underrun) |-> (o_word_bytes != '0 && o_wire_word == '0))
        else $error("underrun result is not a silent pop");

    a_acc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && t_req'(i_req_type) == REQ_WRITE && n_o_acc) |=> (r_count != '0))
        else $error("stored write left the fifo empty");
`endif

endmodule

### src/psfp_ram.sv
// generic single-clock ram, one write port and one read port with registered read
// no dependencies
module psfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for pcm_sample_fifo_packer: directed and random requests
// against an in-bench fifo/container model, with random idling on both channels
// depends on psfp_pkg and pcm_sample_fifo_packer
`timescale 1ns / 1ps

module testbench;
    import psfp_pkg::*;

    // codes outside the package enums that the ports still allow
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    localparam logic [FMT_W-1:0] FMT_SPARE   = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] wire_word;
        logic [BYTES_W-1:0]  word_bytes;
        logic                accepted;
        logic                underrun;
        logic [QS_W-1:0]     queued_samples;
    } t_pcm_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [REQ_W-1:0]           i_req_type = REQ_WRITE;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [SAMPLE_W-1:0]        o_wire_word;
    logic [BYTES_W-1:0]         o_word_bytes;
    logic                       o_accepted;
    logic                       o_underrun;
    logic [QS_W-1:0]            o_queued_samples;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [FMT_W-1:0]           i_cfg_data = FMT_32;

    // fifo model state
    logic [SAMPLE_W-1:0] sample_mem [FIFO_DEPTH];
    int                  rd_ptr = 0;
    int                  wr_ptr = 0;
    int                  fill_level = 0;
    logic [FMT_W-1:0]    container = FMT_32;

    t_pcm_result results_due [$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        quiet_mode = 1'b0;
    int          send_run = 0;
    int          stall_left = 0;
    int          calm_left = 0;

    pcm_sample_fifo_packer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_wire_word      (o_wire_word),
        .o_word_bytes     (o_word_bytes),
        .o_accepted       (o_accepted),
        .o_underrun       (o_underrun),
        .o_queued_samples (o_queued_samples),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL pcm_sample_fifo_packer");
            $finish;
        end
    end

    // receiver backpressure: short stall bursts, calm stretches of varying length
    always @(posedge i_clk) begin
        if (quiet_mode) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            i_out_stall <= 1'b1;
        end else begin
            calm_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 3);
            i_out_stall <= 1'b0;
        end
    end

    // advances the fifo model by one request and returns the result it owes
    function automatic t_pcm_result model_request(input logic [REQ_W-1:0] kind,
                                                  input logic [SAMPLE_W-1:0] smp);
        t_pcm_result         r;
        logic [SAMPLE_W-1:0] word;
        r = '0;
        word = '0;
        case (kind)
            REQ_WRITE: begin
                if (fill_level < FIFO_DEPTH) begin
                    sample_mem[wr_ptr] = smp;
                    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                    fill_level++;
                    r.accepted = 1'b1;
                end
            end
            REQ_POP: begin
                if (fill_level != 0) begin
                    word = sample_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
                    fill_level--;
                end else begin
                    r.underrun = 1'b1;
                end
                case (container)
                    FMT_32: begin
                        r.wire_word  = word;
                        r.word_bytes = BYTES_32;
                    end
                    FMT_24: begin
                        r.wire_word  = {8'h00, word[31:8]};
                        r.word_bytes = BYTES_24;
                    end
                    default: begin
                        r.wire_word  = {16'h0000, word[31:16]};
                        r.word_bytes = BYTES_16;
                    end
                endcase
            end
            REQ_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                fill_level = 0;
            end
            default: ;
        endcase
        r.queued_samples = QS_W'(fill_level);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_pcm_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (results_due.size() == 0) begin
                error_count++;
                $error("result with no request outstanding");
            end else begin
                want = results_due.pop_front();
                check_field("wire_word", want.wire_word, o_wire_word);
                check_field("word_bytes", 32'(want.word_bytes), 32'(o_word_bytes));
                check_field("accepted", 32'(want.accepted), 32'(o_accepted));
                check_field("underrun", 32'(want.underrun), 32'(o_underrun));
                check_field("queued_samples", 32'(want.queued_samples),
                            32'(o_queued_samples));
            end
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SAMPLE_W-1:0] smp);
        i_req_type <= kind;
        i_sample   <= smp;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        results_due.push_back(model_request(kind, smp));
        if (send_run > 0) begin
            send_run--;
        end else if (!quiet_mode) begin
            case ($urandom_range(0, 3))
                0: begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
                1: send_run = $urandom_range(8, 40);
                default: ;
            endcase
        end
    endtask

    // format changes only with the block drained
    task automatic write_container(input logic [FMT_W-1:0] fmt);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_data  <= fmt;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        container = fmt;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_requests();
        send_request(REQ_POP, $urandom);
        send_request(REQ_IGNORED, $urandom);
        send_request(REQ_CLEAR, $urandom);
        send_request(REQ_POP, 32'h0000_0000);
    endtask

    task automatic test_containers();
        logic [FMT_W-1:0] fmts [4];
        int i;
        fmts = '{FMT_32, FMT_24, FMT_16, FMT_SPARE};
        for (i = 0; i < 4; i++) begin
            write_container(fmts[i]);
            send_request(REQ_WRITE, 32'h8000_0000);
            send_request(REQ_WRITE, 32'h7FFF_FFFF);
            send_request(REQ_POP, 32'hFFFF_FFFF);
            send_request(REQ_POP, 32'h0000_0000);
            // third pop runs dry: silence in the current container
            send_request(REQ_POP, $urandom);
        end
    endtask

    task automatic test_clear();
        write_container(FMT_24);
        send_request(REQ_WRITE, 32'h1234_5678);
        send_request(REQ_WRITE, 32'h9ABC_DEF0);
        send_request(REQ_CLEAR, 32'hFFFF_FFFF);
        send_request(REQ_POP, $urandom);
        send_request(REQ_WRITE, 32'h0FED_CBA9);
        send_request(REQ_POP, $urandom);
    endtask

    // fill deep, then drain one past empty
    task automatic test_fill_and_drain();
        int i;
        write_container(FMT_32);
        send_request(REQ_CLEAR, $urandom);
        for (i = 0; i < 40; i++)
            send_request(REQ_WRITE, pick_sample());
        for (i = 0; i <= 40; i++)
            send_request(REQ_POP, $urandom);
    endtask

    task automatic run_mix(input int items, input int write_pct);
        int counted;
        int roll;
        counted = 0;
        while (counted < items) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_request(REQ_CLEAR, $urandom);
                counted++;
            end else if (roll < 5) begin
                send_request(REQ_IGNORED, $urandom);
            end else if (roll < 5 + write_pct) begin
                send_request(REQ_WRITE, pick_sample());
                counted++;
            end else begin
                send_request(REQ_POP, $urandom);
                counted++;
            end
        end
    endtask

    task automatic test_random_mix();
        logic [FMT_W-1:0] fmts [6];
        int               write_pcts [6];
        int               phase;
        fmts = '{FMT_32, FMT_16, FMT_SPARE, FMT_24, FMT_32, FMT_16};
        // alternate filling and draining so the level wanders and hits empty
        write_pcts = '{75, 30, 50, 80, 25, 50};
        for (phase = 0; phase < 6; phase++) begin
            write_container(fmts[phase]);
            run_mix(90, write_pcts[phase]);
        end
    endtask

    task automatic test_back_to_back();
        write_container(FMT_24);
        quiet_mode <= 1'b1;
        send_run = 0;
        run_mix(60, 50);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_requests();
        test_containers();
        test_clear();
        test_fill_and_drain();
        test_random_mix();
        test_back_to_back();

        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS pcm_sample_fifo_packer");
        end else begin
            $display("FAIL pcm_sample_fifo_packer");
        end
        $finish;
    end

endmodule
